[rtl/core/deq_pkg.sv]
// Shared types and codes for the double-ended queue unit.
package deq_pkg;

  localparam int REQ_W = 3;
  localparam int VAL_W = 32;
  localparam int ST_W  = 3;

  // request codes on the input channel
  localparam logic [REQ_W-1:0] REQ_ADD_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD_REAR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REM_FRONT = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REM_REAR  = 3'd3;

  // result status codes
  localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 3'd2;
  localparam logic [ST_W-1:0] ST_LISTED    = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  // operation kinds after classification
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    at_front;
    logic signed [VAL_W-1:0] value;
  } deq_op_t;

endpackage

[rtl/core/deq_in_if.sv]
// Request channel: valid/ready handshake with request type and value.
interface deq_in_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::REQ_W-1:0]         req_type;
  logic signed [deq_pkg::VAL_W-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

[rtl/core/deq_out_if.sv]
// Result channel: valid/ready handshake with status, value and last flag.
interface deq_out_if;
  logic                              valid;
  logic                              ready;
  logic [deq_pkg::ST_W-1:0]          status;
  logic signed [deq_pkg::VAL_W-1:0]  value_res;
  logic                              last;

  modport source (output valid, output status, output value_res, output last, input ready);
  modport sink   (input valid, input status, input value_res, input last, output ready);
endinterface

[rtl/core/double_ended_queue_unit.sv]
// Bounded double-ended queue of CAPACITY 32-bit entries kept in a ring buffer. Requests
// add at the front or rear, remove from the front or rear, or list all entries front to
// rear; status codes report underflow, overflow and an empty listing. Requests enter a
// two-entry queue at once and are carried out one at a time by the back end: an add is
// done at dispatch, a remove steps through dispatch, registered memory read and result
// load, and a list repeats read and load per entry over the memory's single read port.
// A result is held in an output register until taken; a full output stalls the back end.
module double_ended_queue_unit #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_req,
  deq_out_if.source out_res
);

  logic             push_valid, push_ready;
  deq_pkg::deq_op_t push_op;
  logic             pop_valid, pop_ready;
  deq_pkg::deq_op_t pop_op;

  deq_front u_front (
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  deq_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  deq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .out_res   (out_res)
  );

endmodule

[rtl/core/deq_front.sv]
// Front end: accepts requests and classifies them into operations.
module deq_front (
  deq_in_if.sink          in_req,
  output logic            push_valid,
  input  logic            push_ready,
  output deq_pkg::deq_op_t push_op
);

  always_comb begin
    push_op.value    = in_req.value;
    push_op.at_front = 1'b0;
    case (in_req.req_type)
      deq_pkg::REQ_ADD_FRONT: begin
        push_op.kind     = deq_pkg::OP_ADD;
        push_op.at_front = 1'b1;
      end
      deq_pkg::REQ_ADD_REAR: begin
        push_op.kind = deq_pkg::OP_ADD;
      end
      deq_pkg::REQ_REM_FRONT: begin
        push_op.kind     = deq_pkg::OP_REMOVE;
        push_op.at_front = 1'b1;
      end
      deq_pkg::REQ_REM_REAR: begin
        push_op.kind = deq_pkg::OP_REMOVE;
      end
      // list all, and unused codes behave the same
      default: begin
        push_op.kind = deq_pkg::OP_LIST;
      end
    endcase
  end

  assign push_valid   = in_req.valid;
  assign in_req.ready = push_ready;

endmodule

[rtl/core/deq_queue.sv]
// Two-entry operation queue between the front end and the back end.
module deq_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  deq_pkg::deq_op_t push_op,
  output logic             pop_valid,
  input  logic             pop_ready,
  output deq_pkg::deq_op_t pop_op
);

  deq_pkg::deq_op_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_op     = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

[rtl/core/deq_back.sv]
// Back end: ring buffer storage, pointer update, list walk and result register.
module deq_back #(
  parameter int CAPACITY = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  deq_pkg::deq_op_t pop_op,
  deq_out_if.source        out_res
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] IDX_MAX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(CAPACITY);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;

  logic signed [deq_pkg::VAL_W-1:0] mem [CAPACITY];
  logic signed [deq_pkg::VAL_W-1:0] rd_data_r;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] remain_r, remain_nxt;
  logic          list_r, list_nxt;

  logic                             out_valid_r, out_valid_nxt;
  logic [deq_pkg::ST_W-1:0]         out_status_r, out_status_nxt;
  logic signed [deq_pkg::VAL_W-1:0] out_value_r, out_value_nxt;
  logic                             out_last_r, out_last_nxt;

  logic          out_free, take;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == IDX_MAX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == '0) ? IDX_MAX : i - 1'b1;
  endfunction

  assign out_free  = !out_valid_r || out_res.ready;
  assign pop_ready = (state_r == S_IDLE) && out_free;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    cur_nxt        = cur_r;
    remain_nxt     = remain_r;
    list_nxt       = list_r;
    out_valid_nxt  = out_valid_r && !out_res.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    mem_we         = 1'b0;
    mem_waddr      = tail_r;

    case (state_r)
      S_IDLE: begin
        if (take) begin
          out_value_nxt = '0;
          out_last_nxt  = 1'b1;
          case (pop_op.kind)
            deq_pkg::OP_ADD: begin
              out_valid_nxt = 1'b1;
              if (count_r == CNT_FULL) begin
                out_status_nxt = deq_pkg::ST_OVERFLOW;
              end else begin
                out_status_nxt = deq_pkg::ST_DONE;
                mem_we         = 1'b1;
                count_nxt      = count_r + 1'b1;
                if (pop_op.at_front) begin
                  mem_waddr = idx_dec(head_r);
                  head_nxt  = idx_dec(head_r);
                end else begin
                  tail_nxt = idx_inc(tail_r);
                end
              end
            end
            deq_pkg::OP_REMOVE: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = deq_pkg::ST_UNDERFLOW;
              end else begin
                count_nxt  = count_r - 1'b1;
                remain_nxt = CNT_ONE;
                list_nxt   = 1'b0;
                state_nxt  = S_ISSUE;
                if (pop_op.at_front) begin
                  cur_nxt  = head_r;
                  head_nxt = idx_inc(head_r);
                end else begin
                  cur_nxt  = idx_dec(tail_r);
                  tail_nxt = idx_dec(tail_r);
                end
              end
            end
            default: begin
              if (count_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                cur_nxt    = head_r;
                remain_nxt = count_r;
                list_nxt   = 1'b1;
                state_nxt  = S_ISSUE;
              end
            end
          endcase
        end
      end
      // read of mem[cur_r] lands in rd_data_r at this edge
      S_ISSUE: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = list_r ? deq_pkg::ST_LISTED : deq_pkg::ST_DONE;
          out_value_nxt  = rd_data_r;
          out_last_nxt   = (remain_r == CNT_ONE);
          if (remain_r == CNT_ONE) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt    = idx_inc(cur_r);
            remain_nxt = remain_r - 1'b1;
            state_nxt  = S_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    remain_r     <= remain_nxt;
    list_r       <= list_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= pop_op.value;
    end
    rd_data_r <= mem[cur_r];
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.status    = out_status_r;
  assign out_res.value_res = out_value_r;
  assign out_res.last      = out_last_r;

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the double-ended queue unit with a request/result predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH      = 32;
  localparam int LONG_HOLD  = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_WAIT  = 100;

  typedef logic [deq_pkg::REQ_W-1:0] req_code_t;

  // list request and the reserved codes that the unit also treats as a list
  localparam req_code_t REQ_LIST_ALL = 3'd4;
  localparam req_code_t REQ_RSVD_5   = 3'd5;
  localparam req_code_t REQ_RSVD_6   = 3'd6;
  localparam req_code_t REQ_RSVD_7   = 3'd7;

  typedef struct packed {
    logic [deq_pkg::REQ_W-1:0]        code;
    logic signed [deq_pkg::VAL_W-1:0] value;
  } deq_req_t;

  typedef struct packed {
    logic [deq_pkg::ST_W-1:0]         status;
    logic signed [deq_pkg::VAL_W-1:0] value_res;
    logic                             last;
  } deq_res_t;

  logic clk;
  logic rst_n;

  deq_in_if  in_ch();
  deq_out_if out_ch();

  double_ended_queue_unit #(.CAPACITY(DEPTH)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_ch),
    .out_res(out_ch)
  );

  // predictor state: ring of entries, 5-bit slots wrap on their own at DEPTH 32
  logic signed [deq_pkg::VAL_W-1:0] ring_mem [DEPTH];
  bit [4:0]    front_slot = '0;
  bit [4:0]    back_slot  = '0;
  int unsigned held       = 0;

  deq_req_t pending_reqs[$];
  deq_res_t expected_res[$];
  deq_req_t drive_req;

  int unsigned n_pushed;
  int unsigned n_accepted = 0;
  int unsigned n_errors   = 0;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  bit          hold_trigger;
  bit          hold_seen;

  function automatic void push_result(logic [deq_pkg::ST_W-1:0] st,
                                      logic signed [deq_pkg::VAL_W-1:0] v,
                                      logic lst);
    deq_res_t r;
    r.status    = st;
    r.value_res = v;
    r.last      = lst;
    expected_res.push_back(r);
  endfunction

  function automatic void predict_request(deq_req_t r);
    bit [4:0]    slot;
    int unsigned k;
    case (r.code)
      deq_pkg::REQ_ADD_FRONT, deq_pkg::REQ_ADD_REAR: begin
        if (held == DEPTH) begin
          push_result(deq_pkg::ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (r.code == deq_pkg::REQ_ADD_FRONT) begin
            front_slot = front_slot - 1'b1;
            ring_mem[front_slot] = r.value;
          end else begin
            ring_mem[back_slot] = r.value;
            back_slot = back_slot + 1'b1;
          end
          held++;
          push_result(deq_pkg::ST_DONE, '0, 1'b1);
        end
      end
      deq_pkg::REQ_REM_FRONT, deq_pkg::REQ_REM_REAR: begin
        if (held == 0) begin
          push_result(deq_pkg::ST_UNDERFLOW, '0, 1'b1);
        end else begin
          if (r.code == deq_pkg::REQ_REM_FRONT) begin
            slot = front_slot;
            front_slot = front_slot + 1'b1;
          end else begin
            back_slot = back_slot - 1'b1;
            slot = back_slot;
          end
          held--;
          push_result(deq_pkg::ST_DONE, ring_mem[slot], 1'b1);
        end
      end
      default: begin
        if (held == 0) begin
          push_result(deq_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          slot = front_slot;
          for (k = 0; k < held; k++) begin
            push_result(deq_pkg::ST_LISTED, ring_mem[slot], k + 1 == held);
            slot = slot + 1'b1;
          end
        end
      end
    endcase
  endfunction

  function automatic logic signed [deq_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return '0;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(logic [deq_pkg::REQ_W-1:0] code,
                          logic signed [deq_pkg::VAL_W-1:0] v);
    deq_req_t r;
    r.code  = code;
    r.value = v;
    pending_reqs.push_back(r);
    n_pushed++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_pushed || expected_res.size() != 0) @(posedge clk);
  endtask

  task automatic push_mix(int unsigned n);
    int unsigned i;
    int unsigned pick;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        push_req($urandom_range(1) ? deq_pkg::REQ_ADD_REAR : deq_pkg::REQ_ADD_FRONT,
                 pick_value());
      else if (pick < 88)
        push_req($urandom_range(1) ? deq_pkg::REQ_REM_REAR : deq_pkg::REQ_REM_FRONT,
                 $urandom);
      else
        push_req(req_code_t'($urandom_range(REQ_LIST_ALL, REQ_RSVD_7)), $urandom);
    end
  endtask

  // fill past capacity, walk, mixed traffic, walk, drain past empty, walk, then mixed traffic
  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, bit long_hold);
    int unsigned i;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (long_hold)
      hold_trigger = ~hold_trigger;
    for (i = 0; i < 36; i++)
      push_req($urandom_range(1) ? deq_pkg::REQ_ADD_REAR : deq_pkg::REQ_ADD_FRONT,
               pick_value());
    push_req(REQ_LIST_ALL, $urandom);
    push_mix(30);
    push_req(req_code_t'($urandom_range(REQ_LIST_ALL, REQ_RSVD_7)), $urandom);
    for (i = 0; i < 36; i++)
      push_req($urandom_range(1) ? deq_pkg::REQ_REM_REAR : deq_pkg::REQ_REM_FRONT,
               $urandom);
    push_req(REQ_LIST_ALL, $urandom);
    push_mix(12);
    wait_drained();
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    n_pushed       = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_trigger   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cases, zero and extreme values, unknown codes, last-element removal
    push_req(REQ_LIST_ALL, '0);
    push_req(deq_pkg::REQ_REM_FRONT, '0);
    push_req(deq_pkg::REQ_REM_REAR, '0);
    push_req(deq_pkg::REQ_ADD_FRONT, '0);
    push_req(deq_pkg::REQ_ADD_REAR, 32'sh7fff_ffff);
    push_req(deq_pkg::REQ_ADD_FRONT, 32'sh8000_0000);
    push_req(deq_pkg::REQ_ADD_REAR, -32'sd1);
    push_req(deq_pkg::REQ_ADD_FRONT, 32'sh5555_aaaa);
    push_req(REQ_LIST_ALL, -32'sd1);
    push_req(REQ_RSVD_5, '0);
    push_req(REQ_RSVD_6, '0);
    push_req(REQ_RSVD_7, '0);
    push_req(deq_pkg::REQ_REM_FRONT, -32'sd1);
    push_req(deq_pkg::REQ_REM_REAR, '0);
    push_req(deq_pkg::REQ_REM_FRONT, '0);
    push_req(deq_pkg::REQ_REM_REAR, '0);
    push_req(deq_pkg::REQ_REM_FRONT, '0);
    push_req(deq_pkg::REQ_REM_REAR, '0);
    push_req(REQ_LIST_ALL, '0);
    push_req(deq_pkg::REQ_ADD_REAR, '0);
    push_req(REQ_LIST_ALL, '0);
    push_req(deq_pkg::REQ_REM_REAR, '0);
    wait_drained();

    run_phase(0, 0, 1'b1);
    run_phase(88, 0, 1'b0);
    run_phase(0, 88, 1'b0);
    run_phase(22, 22, 1'b0);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_errors == 0 && expected_res.size() == 0)
      $display("PASS double_ended_queue_unit");
    else
      $display("FAIL double_ended_queue_unit");
    $finish;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.req_type <= '0;
      in_ch.value    <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_req = pending_reqs.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.req_type <= drive_req.code;
        in_ch.value    <= drive_req.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver, with a long hold-off on each toggle of hold_trigger
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_seen    <= 1'b0;
      hold_left    <= 0;
    end else if (hold_trigger != hold_seen) begin
      hold_seen    <= hold_trigger;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: check results against the oldest expectation, then predict new requests
  always @(posedge clk) begin
    deq_res_t want;
    deq_req_t got_req;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_res.size() == 0) begin
          n_errors++;
          $error("unexpected result: status %0d value_res %0d last %0b",
                 out_ch.status, out_ch.value_res, out_ch.last);
        end else begin
          want = expected_res.pop_front();
          if (out_ch.status !== want.status) begin
            n_errors++;
            $error("status: expected %0d actual %0d", want.status, out_ch.status);
          end
          if (out_ch.value_res !== want.value_res) begin
            n_errors++;
            $error("value_res: expected %0d actual %0d", want.value_res, out_ch.value_res);
          end
          if (out_ch.last !== want.last) begin
            n_errors++;
            $error("last: expected %0b actual %0b", want.last, out_ch.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        got_req.code  = in_ch.req_type;
        got_req.value = in_ch.value;
        predict_request(got_req);
        n_accepted++;
      end
    end
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL double_ended_queue_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
